// ===== src/html_rawtext_end_tag_scanner_top_macros.svh =====
// Assertion macros for the raw text end tag scanner.
// Expects signals named clock and reset in the module that uses them.
`ifndef HTML_RAWTEXT_END_TAG_SCANNER_TOP_MACROS_SVH
`define HTML_RAWTEXT_END_TAG_SCANNER_TOP_MACROS_SVH

// Checked property, disabled while reset is high.
`define HRAW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked property that also holds during reset.
`define HRAW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== src/hraw_pkg.sv =====
// Shared types and constants for the raw text end tag scanner.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package hraw_pkg;

   localparam int ByteWidth     = 8;
   localparam int OffsetWidth   = 32;
   localparam int NameRegWidth  = 64;
   localparam int LengthWidth   = 4;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 64;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [OffsetWidth-1:0] offset_type;
   typedef logic [LengthWidth-1:0] length_type;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_EXPECTED_NAME   = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_EXPECTED_LENGTH = 1'd1;

   typedef enum logic [1:0] {
      EVENT_NONE     = 2'd0,
      EVENT_NUL      = 2'd1,
      EVENT_TEXT_END = 2'd2,
      EVENT_MATCH    = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      FOLLOW_DATA       = 2'd0,
      FOLLOW_ATTRIBUTES = 2'd1,
      FOLLOW_SELF_CLOSE = 2'd2
   } follow_type;

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_TEXT = 5'b00010,
      MODE_LT   = 5'b00100,
      MODE_OPEN = 5'b01000,
      MODE_NAME = 5'b10000
   } mode_type;

   localparam byte_type CHAR_LT    = 8'h3C;
   localparam byte_type CHAR_SLASH = 8'h2F;
   localparam byte_type CHAR_GT    = 8'h3E;
   localparam byte_type CHAR_TAB   = 8'h09;
   localparam byte_type CHAR_LF    = 8'h0A;
   localparam byte_type CHAR_FF    = 8'h0C;
   localparam byte_type CHAR_CR    = 8'h0D;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_NUL   = 8'h00;
   localparam byte_type CASE_BIT   = 8'h20;

   localparam length_type NameCountMax = 4'd15;

   function automatic logic is_letter(input byte_type b);
      logic res;
      res = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
      return res;
   endfunction

   function automatic logic is_space(input byte_type b);
      logic res;
      res = (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_FF) || (b == CHAR_CR)
         || (b == CHAR_SPACE);
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== src/hraw_req_if.sv =====
// Input channel of the scanner: one raw text byte per transaction.
// Depends on hraw_pkg for field types.
`default_nettype none

interface hraw_req_if import hraw_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type byte_in;
   logic     at_end;
   logic     restart;

   modport source (output valid, output byte_in, output at_end, output restart,
                   input ready);
   modport sink   (input valid, input byte_in, input at_end, input restart,
                   output ready);
endinterface

`default_nettype wire

// ===== src/hraw_rsp_if.sv =====
// Result channel of the scanner: one result per input transaction.
// Depends on hraw_pkg for field types.
`default_nettype none

interface hraw_rsp_if import hraw_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] event_res;
   logic [1:0] follow_mode;
   offset_type text_begin;
   offset_type text_finish;
   offset_type tag_begin;
   offset_type tag_finish;
   logic       text_has_null;

   modport source (output valid, output event_res, output follow_mode,
                   output text_begin, output text_finish, output tag_begin,
                   output tag_finish, output text_has_null, input ready);
   modport sink   (input valid, input event_res, input follow_mode,
                   input text_begin, input text_finish, input tag_begin,
                   input tag_finish, input text_has_null, output ready);
endinterface

`default_nettype wire

// ===== src/html_rawtext_end_tag_scanner_top.sv =====
// Raw text end tag scanner. A result is valid in the cycle after its transaction.
// Throughput: one byte per cycle unless stalled; state updates in the accepting cycle.
// The result register accepts a new transaction while its current result is being taken.
// Reset (synchronous, active high) returns to idle, clears the offset counter,
// empties the result register and sets the expected name to 0 with length 1.
`default_nettype none

`include "html_rawtext_end_tag_scanner_top_macros.svh"

module html_rawtext_end_tag_scanner_top
   import hraw_pkg::*;
#(
   parameter int MAX_NAME_BYTES = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   hraw_req_if.sink                      req_chan,
   hraw_rsp_if.source                    rsp_chan,
   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   localparam int         NameBits     = 8 * MAX_NAME_BYTES;
   localparam length_type MaxNameBytes = LengthWidth'(MAX_NAME_BYTES);

   // Configuration.
   logic [NameBits-1:0] name_ff;
   length_type          len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff <= '0;
         len_ff  <= 4'd1;
      end else if (csr_we) begin
         if (csr_index == CSR_EXPECTED_NAME) begin
            name_ff <= csr_wdata[NameBits-1:0];
         end
         if (csr_index == CSR_EXPECTED_LENGTH) begin
            len_ff <= csr_wdata[LengthWidth-1:0];
         end
      end
   end

   // Scan state.
   mode_type   mode_ff, mode_in;
   offset_type offset_ff, offset_in;
   offset_type text_start_ff, text_start_in;
   offset_type last_lt_ff, last_lt_in;
   offset_type name_start_ff, name_start_in;
   length_type count_ff, count_in;
   logic       match_ff, match_in;
   logic       null_ff, null_in;

   // Result register.
   logic       out_valid_ff;
   event_type  ev_ff, ev_in;
   follow_type follow_ff, follow_in;
   offset_type text_begin_ff;
   offset_type tfin_ff, tfin_in;
   offset_type gbeg_ff, gbeg_in;
   offset_type gfin_ff, gfin_in;
   logic       has_null_ff;

   logic     accept;
   byte_type b;
   logic     eof;
   logic     fresh;
   mode_type mode_eff;
   logic     do_text;

   // Name comparison for a letter at position cnt_base.
   length_type cnt_base;
   logic       match_base;
   byte_type   want;
   logic       letter_ok;
   logic       match_new;
   length_type cnt_new;
   logic       delim;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign b              = req_chan.byte_in;
   assign eof            = req_chan.at_end;
   assign fresh          = req_chan.restart || (mode_ff == MODE_IDLE);
   assign mode_eff       = fresh ? MODE_TEXT : mode_ff;

   assign cnt_base   = (mode_eff == MODE_OPEN) ? '0 : count_ff;
   assign match_base = (mode_eff == MODE_OPEN) ? 1'b1 : match_ff;

   always_comb begin
      want = '0;
      for (int i = 0; i < MAX_NAME_BYTES; i++) begin
         if (cnt_base == LengthWidth'(i)) begin
            want = name_ff[8*i +: 8];
         end
      end
   end

   assign letter_ok = (cnt_base < len_ff) && (cnt_base < MaxNameBytes)
                   && ((b | CASE_BIT) == want);
   assign match_new = match_base && letter_ok;
   assign cnt_new   = (cnt_base == NameCountMax) ? NameCountMax : cnt_base + 4'd1;
   assign delim     = is_space(b) || (b == CHAR_SLASH) || (b == CHAR_GT);

   always_comb begin
      mode_in       = mode_eff;
      offset_in     = eof ? offset_ff : offset_ff + 32'd1;
      text_start_in = fresh ? offset_ff : text_start_ff;
      last_lt_in    = last_lt_ff;
      name_start_in = name_start_ff;
      count_in      = count_ff;
      match_in      = match_ff;
      null_in       = fresh ? 1'b0 : null_ff;
      ev_in         = EVENT_NONE;
      follow_in     = FOLLOW_DATA;
      tfin_in       = '0;
      gbeg_in       = '0;
      gfin_in       = '0;
      do_text       = 1'b0;

      // A failed end tag falls through to text handling of the same byte.
      unique case (mode_eff)
         MODE_LT: begin
            if (!eof && (b == CHAR_SLASH)) begin
               mode_in = MODE_OPEN;
            end else begin
               do_text = 1'b1;
            end
         end
         MODE_OPEN, MODE_NAME: begin
            if (!eof && is_letter(b)) begin
               if (mode_eff == MODE_OPEN) begin
                  name_start_in = offset_ff;
               end
               count_in = cnt_new;
               match_in = match_new;
               mode_in  = MODE_NAME;
            end else if ((mode_eff == MODE_NAME) && !eof && delim && match_ff
                         && (count_ff == len_ff) && (len_ff <= MaxNameBytes)) begin
               ev_in     = EVENT_MATCH;
               follow_in = (b == CHAR_GT) ? FOLLOW_DATA
                         : ((b == CHAR_SLASH) ? FOLLOW_SELF_CLOSE : FOLLOW_ATTRIBUTES);
               tfin_in   = last_lt_ff;
               gbeg_in   = name_start_ff;
               gfin_in   = offset_ff;
               mode_in   = MODE_IDLE;
            end else begin
               do_text = 1'b1;
            end
         end
         default: begin
            do_text = 1'b1;
         end
      endcase

      if (do_text) begin
         mode_in = MODE_TEXT;
         priority if (eof) begin
            ev_in   = EVENT_TEXT_END;
            tfin_in = offset_ff;
            mode_in = MODE_IDLE;
         end else if (b == CHAR_LT) begin
            last_lt_in = offset_ff;
            mode_in    = MODE_LT;
         end else if (b == CHAR_NUL) begin
            null_in = 1'b1;
            ev_in   = EVENT_NUL;
         end else begin
            mode_in = MODE_TEXT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         offset_ff     <= '0;
         text_start_ff <= '0;
         last_lt_ff    <= '0;
         name_start_ff <= '0;
         count_ff      <= '0;
         match_ff      <= 1'b1;
         null_ff       <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         offset_ff     <= offset_in;
         text_start_ff <= text_start_in;
         last_lt_ff    <= last_lt_in;
         name_start_ff <= name_start_in;
         count_ff      <= count_in;
         match_ff      <= match_in;
         null_ff       <= null_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ev_ff         <= ev_in;
         follow_ff     <= follow_in;
         text_begin_ff <= text_start_in;
         tfin_ff       <= tfin_in;
         gbeg_ff       <= gbeg_in;
         gfin_ff       <= gfin_in;
         has_null_ff   <= null_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.event_res     = ev_ff;
   assign rsp_chan.follow_mode   = follow_ff;
   assign rsp_chan.text_begin    = text_begin_ff;
   assign rsp_chan.text_finish   = tfin_ff;
   assign rsp_chan.tag_begin     = gbeg_ff;
   assign rsp_chan.tag_finish    = gfin_ff;
   assign rsp_chan.text_has_null = has_null_ff;

   `HRAW_ASSERT(a_result_follows, accept |=> rsp_chan.valid, "accepted transaction gave no result")
   `HRAW_ASSERT(a_no_overwrite,
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready,
      "result register overwritten while stalled")
   `HRAW_ASSERT(a_match_idles,
      (accept && (ev_in == EVENT_MATCH)) |=> (mode_ff == MODE_IDLE),
      "scanner not idle after a match")
   `HRAW_ASSERT(a_name_counted, (mode_ff == MODE_NAME) |-> (count_ff != '0),
      "name state with an empty name count")
   `HRAW_ASSERT_ALWAYS(a_reset_empties, $past(reset) |-> !rsp_chan.valid,
      "result valid right after reset")

endmodule

`default_nettype wire
